/* sv/ascii_hex_can_frame_parser_macros.svh */
// Assertion macros shared by the ASCII hex CAN frame parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASCII_HEX_CAN_FRAME_PARSER_MACROS_SVH
`define ASCII_HEX_CAN_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfp assertion failed");

// Next-cycle implication, checked outside reset.
`define ACFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfp assertion failed");

`endif

/* sv/acfp_pkg.sv */
// Package for the ASCII hex CAN frame parser: character codes, stage and result types,
// and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package acfp_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int PAYLOAD_LANES  = 8;
  localparam int MIN_LEN        = 7;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
  localparam logic [3:0] TRAIL_MAX     = 4'd15;
  localparam logic [4:0] CHARS_MAX     = 5'd31;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } stage_t;

  typedef struct packed {
    logic        status;
    logic        extended;
    logic        remote;
    logic [31:0] can_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [4:0]  chars_used;
  } result_t;

  // Bit 4 set means the character is not a hex digit; bits 3:0 hold the value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

/* sv/acfp_in_reg.sv */
// Input register stage of the ASCII hex CAN frame parser.
// Depends on acfp_pkg for the stage type.
`timescale 1ns / 1ps

module acfp_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_stall,
  input  logic [7:0]      char_byte,
  input  logic            last_char,
  input  logic            out_free,
  output logic            step,
  output acfp_pkg::stage_t stage
);

  logic             held;
  logic             advance;
  logic             load;
  acfp_pkg::stage_t stage_reg;

  // A character that ends the message can only move on when the result register is free.
  assign advance    = !stage_reg.last_char || out_free;
  assign step       = held && advance;
  assign char_stall = held && !advance;
  assign load       = char_valid && !char_stall;
  assign stage      = stage_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_reg.char_byte <= char_byte;
      stage_reg.last_char <= last_char;
    end
  end

endmodule

/* sv/acfp_parser.sv */
// Parse state and per-character update of the ASCII hex CAN frame parser.
// Depends on acfp_pkg and on the assertion macro header.
`timescale 1ns / 1ps
`include "ascii_hex_can_frame_parser_macros.svh"

module acfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  acfp_pkg::stage_t  stage,
  output logic              res_load,
  output acfp_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_START, PH_TYPE, PH_ID, PH_RN, PH_DHI, PH_DLO, PH_CR, PH_LF, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [31:0] id_accum, id_accum_next;
  logic [63:0] data_accum, data_accum_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        ext_flag, ext_flag_next;
  logic        rtr_flag, rtr_flag_next;
  logic        error_flag, error_flag_next;
  logic [4:0]  char_count, char_count_next;

  logic [7:0]  ch;
  logic [4:0]  hv;
  logic        is_hex;
  logic [3:0]  id_digits;
  logic [5:0]  total;
  logic        bad;
  logic        at_start;
  logic        std_id_fits;

  assign ch     = stage.char_byte;
  assign hv     = acfp_pkg::hex_value(ch);
  assign is_hex = !hv[4];

  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    id_accum_next    = id_accum;
    data_accum_next  = data_accum;
    byte_count_next  = byte_count;
    high_nibble_next = high_nibble;
    ext_flag_next    = ext_flag;
    rtr_flag_next    = rtr_flag;
    error_flag_next  = error_flag;
    char_count_next  = char_count;
    id_digits        = digit_count + 4'd1;

    // After the line feed only the trailing characters are counted.
    if (phase == PH_DONE) begin
      if (digit_count < acfp_pkg::TRAIL_MAX) begin
        digit_count_next = digit_count + 4'd1;
      end
    end else if (char_count < acfp_pkg::CHARS_MAX) begin
      char_count_next = char_count + 5'd1;
    end

    if (!error_flag) begin
      case (phase)
        PH_START: begin
          if (ch == acfp_pkg::CH_COLON) phase_next = PH_TYPE;
          else error_flag_next = 1'b1;
        end
        PH_TYPE: begin
          if (ch == acfp_pkg::CH_X) begin
            ext_flag_next = 1'b1;
            phase_next    = PH_ID;
          end else if (ch == acfp_pkg::CH_S) begin
            phase_next = PH_ID;
          end else if (ch == acfp_pkg::CH_R) begin
            rtr_flag_next = 1'b1;
            phase_next    = PH_DHI;
          end else if (ch == acfp_pkg::CH_N) begin
            phase_next = PH_DHI;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        PH_ID: begin
          if (!is_hex) begin
            error_flag_next = 1'b1;
          end else begin
            id_accum_next    = {id_accum[27:0], hv[3:0]};
            digit_count_next = id_digits;
            if (id_digits >= (ext_flag ? acfp_pkg::EXT_ID_DIGITS
                                       : acfp_pkg::STD_ID_DIGITS)) begin
              phase_next = PH_RN;
            end
          end
        end
        PH_RN: begin
          if (ch == acfp_pkg::CH_R) begin
            rtr_flag_next = 1'b1;
            phase_next    = PH_DHI;
          end else if (ch == acfp_pkg::CH_N) begin
            phase_next = PH_DHI;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        PH_DHI: begin
          if (ch == acfp_pkg::CH_SEMI) begin
            phase_next = PH_CR;
          end else if (byte_count < 4'(acfp_pkg::MAX_DATA_BYTES) && is_hex) begin
            high_nibble_next = hv[3:0];
            phase_next       = PH_DLO;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        PH_DLO: begin
          if (!is_hex) begin
            error_flag_next = 1'b1;
          end else begin
            for (int i = 0; i < acfp_pkg::PAYLOAD_LANES; i++) begin
              if (byte_count[2:0] == 3'(i)) begin
                data_accum_next[8*i +: 8] = data_accum[8*i +: 8] | {high_nibble, hv[3:0]};
              end
            end
            byte_count_next = byte_count + 4'd1;
            phase_next      = PH_DHI;
          end
        end
        PH_CR: begin
          if (ch == acfp_pkg::CH_CR) phase_next = PH_LF;
          else error_flag_next = 1'b1;
        end
        PH_LF: begin
          if (ch == acfp_pkg::CH_LF) phase_next = PH_DONE;
          else error_flag_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Trailing characters after the line feed still count toward the minimum length.
  always_comb begin
    total = {1'b0, char_count_next} +
            ((phase_next == PH_DONE) ? {2'b00, digit_count_next} : 6'd0);
    bad   = error_flag_next || (total < 6'(acfp_pkg::MIN_LEN)) ||
            (phase_next inside {PH_START, PH_TYPE, PH_ID, PH_RN, PH_DLO});

    res.status      = bad;
    res.extended    = bad ? 1'b0  : ext_flag_next;
    res.remote      = bad ? 1'b0  : rtr_flag_next;
    res.can_id      = bad ? 32'd0 : id_accum_next;
    res.data_length = bad ? 4'd0  : byte_count_next;
    res.payload     = bad ? 64'd0 : data_accum_next;
    res.chars_used  = bad ? 5'd0  : char_count_next;
  end

  assign res_load = step && stage.last_char;

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase       <= PH_START;
      digit_count <= 4'd0;
      id_accum    <= 32'd0;
      data_accum  <= 64'd0;
      byte_count  <= 4'd0;
      high_nibble <= 4'd0;
      ext_flag    <= 1'b0;
      rtr_flag    <= 1'b0;
      error_flag  <= 1'b0;
      char_count  <= 5'd0;
    end else if (step) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      id_accum    <= id_accum_next;
      data_accum  <= data_accum_next;
      byte_count  <= byte_count_next;
      high_nibble <= high_nibble_next;
      ext_flag    <= ext_flag_next;
      rtr_flag    <= rtr_flag_next;
      error_flag  <= error_flag_next;
      char_count  <= char_count_next;
    end
  end

  assign at_start    = (phase == PH_START) && (char_count == 5'd0);
  assign std_id_fits = (res.can_id[31:12] == 20'd0);

  `ACFP_ASSERT_NEXT(a_restart_after_last, clk, rst, res_load, at_start)
  `ACFP_ASSERT_NOW(a_std_id_narrow, clk, rst, res_load && !res.extended, std_id_fits)

endmodule

/* sv/acfp_out_reg.sv */
// Result register of the ASCII hex CAN frame parser.
// Depends on acfp_pkg for the result type.
`timescale 1ns / 1ps

module acfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  acfp_pkg::result_t res,
  input  logic              frame_stall,
  output logic              frame_valid,
  output logic              out_free,
  output acfp_pkg::result_t frame
);

  assign out_free = !frame_valid || !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (res_load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      frame <= res;
    end
  end

endmodule

/* sv/ascii_hex_can_frame_parser.sv */
// Top level of the ASCII hex CAN frame parser: input stage, parser and result register.
// Depends on acfp_pkg, acfp_in_reg, acfp_parser, acfp_out_reg and the macro header.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-----------------------------------------
//   char    | in        | char_valid / char_stall    | char_byte, last_char
//   frame   | out       | frame_valid / frame_stall  | status, extended, remote, can_id,
//           |           |                            | data_length, payload, chars_used
//
// One character is taken in every cycle unless the last character of a message waits for a
// free result register. A character is registered in the input register and is folded into
// the parse state when it steps on; the character marked last also loads the result register
// at that edge, from which the frame is offered. Reset (rst, synchronous) clears the stage,
// the parse state and the result valid flag. A stalled result holds the last character in
// the input register and stalls the character channel only in that case.
`timescale 1ns / 1ps
`include "ascii_hex_can_frame_parser_macros.svh"

module ascii_hex_can_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic        status,
  output logic        extended,
  output logic        remote,
  output logic [31:0] can_id,
  output logic [3:0]  data_length,
  output logic [63:0] payload,
  output logic [4:0]  chars_used
);

  logic              out_free;
  logic              step;
  logic              res_load;
  acfp_pkg::stage_t  stage;
  acfp_pkg::result_t res;
  acfp_pkg::result_t frame;
  logic              err_fields_zero;
  logic              length_ok;

  // The input stage lets ordinary characters through at full rate; only the character
  // that closes a message waits for room in the result register.
  acfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_byte  (char_byte),
    .last_char  (last_char),
    .out_free   (out_free),
    .step       (step),
    .stage      (stage)
  );

  // The parser holds the message state and forms the result for the closing character.
  acfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .stage    (stage),
    .res_load (res_load),
    .res      (res)
  );

  // The result register keeps a finished frame until the frame transaction completes.
  acfp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res_load    (res_load),
    .res         (res),
    .frame_stall (frame_stall),
    .frame_valid (frame_valid),
    .out_free    (out_free),
    .frame       (frame)
  );

  assign status      = frame.status;
  assign extended    = frame.extended;
  assign remote      = frame.remote;
  assign can_id      = frame.can_id;
  assign data_length = frame.data_length;
  assign payload     = frame.payload;
  assign chars_used  = frame.chars_used;

  // A malformed message must leave every data field of its frame at zero.
  assign err_fields_zero = (can_id == 32'd0) && (payload == 64'd0) &&
                           (chars_used == 5'd0) && (data_length == 4'd0);
  assign length_ok       = (data_length <= 4'(acfp_pkg::MAX_DATA_BYTES));

  `ACFP_ASSERT_NOW(a_error_fields_clear, clk, rst, frame_valid && status, err_fields_zero)
  `ACFP_ASSERT_NOW(a_length_in_range, clk, rst, frame_valid && !status, length_ok)

endmodule

/* bench/can_frame_checker.sv */
// Frame checker for the ASCII hex CAN frame parser: mirrors the parse of every accepted
// character and compares each delivered frame transaction with the oldest predicted frame.
// Depends on acfp_pkg for the character codes, limits and the result structure.
`timescale 1ns / 1ps

module can_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  input  logic        frame_valid,
  input  logic        frame_stall,
  input  logic        status,
  input  logic        extended,
  input  logic        remote,
  input  logic [31:0] can_id,
  input  logic [3:0]  data_length,
  input  logic [63:0] payload,
  input  logic [4:0]  chars_used,
  output int          mismatches,
  output int          frames_pending
);
  import acfp_pkg::*;

  typedef enum logic [3:0] {
    WAIT_COLON, WAIT_TYPE, IN_ID, WAIT_RN, DATA_HI, DATA_LO, WAIT_CR, WAIT_LF, DONE_TAIL
  } phase_t;

  phase_t      ph;
  logic [3:0]  dig_n;
  logic [31:0] id_acc;
  logic [63:0] data_acc;
  logic [3:0]  nbytes;
  logic [3:0]  hi_nib;
  logic        is_ext;
  logic        is_rtr;
  logic        broken;
  logic [4:0]  n_chars;

  result_t     frames_due[$];
  result_t     want;
  int          errors = 0;

  function automatic void clear_parse();
    ph       = WAIT_COLON;
    dig_n    = '0;
    id_acc   = '0;
    data_acc = '0;
    nbytes   = '0;
    hi_nib   = '0;
    is_ext   = 1'b0;
    is_rtr   = 1'b0;
    broken   = 1'b0;
    n_chars  = '0;
  endfunction

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  function automatic void advance_phase(input logic [7:0] c);
    logic [4:0] h;
    h = decode_hex(c);
    case (ph)
      WAIT_COLON: begin
        if (c == CH_COLON) ph = WAIT_TYPE;
        else broken = 1'b1;
      end
      WAIT_TYPE: begin
        if (c == CH_X) begin
          is_ext = 1'b1;
          ph = IN_ID;
        end else if (c == CH_S) begin
          ph = IN_ID;
        end else if (c == CH_R) begin
          is_rtr = 1'b1;
          ph = DATA_HI;
        end else if (c == CH_N) begin
          ph = DATA_HI;
        end else begin
          broken = 1'b1;
        end
      end
      IN_ID: begin
        if (h[4]) begin
          broken = 1'b1;
        end else begin
          id_acc = {id_acc[27:0], h[3:0]};
          dig_n  = dig_n + 4'd1;
          if (dig_n >= (is_ext ? EXT_ID_DIGITS : STD_ID_DIGITS)) ph = WAIT_RN;
        end
      end
      WAIT_RN: begin
        if (c == CH_R) begin
          is_rtr = 1'b1;
          ph = DATA_HI;
        end else if (c == CH_N) begin
          ph = DATA_HI;
        end else begin
          broken = 1'b1;
        end
      end
      DATA_HI: begin
        if (c == CH_SEMI) begin
          ph = WAIT_CR;
        end else if (nbytes < MAX_DATA_BYTES && !h[4]) begin
          hi_nib = h[3:0];
          ph = DATA_LO;
        end else begin
          broken = 1'b1;
        end
      end
      DATA_LO: begin
        if (h[4]) begin
          broken = 1'b1;
        end else begin
          data_acc = data_acc | (64'({hi_nib, h[3:0]}) << (8 * nbytes[2:0]));
          nbytes   = nbytes + 4'd1;
          ph = DATA_HI;
        end
      end
      WAIT_CR: begin
        if (c == CH_CR) ph = WAIT_LF;
        else broken = 1'b1;
      end
      WAIT_LF: begin
        if (c == CH_LF) ph = DONE_TAIL;
        else broken = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // Folds one character into the mirrored parse; the last character of a message
  // queues the frame it should produce.
  function automatic void parse_char(input logic [7:0] c, input logic is_last);
    int      total;
    logic    bad;
    result_t r;
    // After the LF the identifier digit counter goes on as the trailing count.
    if (ph == DONE_TAIL) begin
      if (dig_n < TRAIL_MAX) dig_n = dig_n + 4'd1;
    end else if (n_chars < CHARS_MAX) begin
      n_chars = n_chars + 5'd1;
    end
    if (!broken) advance_phase(c);
    if (is_last) begin
      total = int'(n_chars) + ((ph == DONE_TAIL) ? int'(dig_n) : 0);
      bad = broken || total < MIN_LEN || ph == WAIT_COLON || ph == WAIT_TYPE ||
            ph == IN_ID || ph == WAIT_RN || ph == DATA_LO;
      r = '0;
      if (bad) begin
        r.status = 1'b1;
      end else begin
        r.extended    = is_ext;
        r.remote      = is_rtr;
        r.can_id      = id_acc;
        r.data_length = nbytes;
        r.payload     = data_acc;
        r.chars_used  = n_chars;
      end
      frames_due.push_back(r);
      clear_parse();
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  initial clear_parse();

  // Frames are compared before the character of the same edge is folded in, so a
  // frame can never be matched against a prediction made in its own cycle.
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      frames_due.delete();
    end else begin
      if (frame_valid && !frame_stall) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: frame with none expected, status %0b can_id %0h payload %0h",
                   $time, status, can_id, payload);
        end else begin
          want = frames_due.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("extended", 64'(want.extended), 64'(extended));
          check_field("remote", 64'(want.remote), 64'(remote));
          check_field("can_id", 64'(want.can_id), 64'(can_id));
          check_field("data_length", 64'(want.data_length), 64'(data_length));
          check_field("payload", want.payload, payload);
          check_field("chars_used", 64'(want.chars_used), 64'(chars_used));
        end
      end
      if (char_valid && !char_stall) parse_char(char_byte, last_char);
    end
    mismatches     <= errors;
    frames_pending <= frames_due.size();
  end

endmodule

/* bench/tb.sv */
// Top level of the ASCII hex CAN frame parser testbench: clock, reset, character stimulus,
// receiver stalling and the verdict. Depends on acfp_pkg, the parser and can_frame_checker.
`timescale 1ns / 1ps

module tb;
  import acfp_pkg::*;

  // Longest run of cycles with no transaction on either channel before the run is
  // declared hung. The longest legitimate quiet stretch is the deliberate receiver
  // hold-off below, plus a short random gap either side of it.
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int CHARS_PER_PHASE = 135;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_byte = '0;
  logic        last_char = 1'b0;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  logic        status;
  logic        extended;
  logic        remote;
  logic [31:0] can_id;
  logic [3:0]  data_length;
  logic [63:0] payload;
  logic [4:0]  chars_used;

  int mismatches;
  int frames_pending;

  // Stimulus controls. The sender's idle rate is used only by the stimulus process;
  // the receiver's stall rate and the hold-off request are read by the stall process.
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic long_hold = 1'b0;
  int   hold_left = 0;
  logic hold_taken = 1'b0;
  int   quiet_cycles = 0;
  int   chars_sent = 0;

  logic [7:0] msg[$];

  ascii_hex_can_frame_parser uut (.*);

  can_frame_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side. A single hold-off of HOLD_CYCLES is counted here once it is
  // requested; otherwise the stall is drawn afresh every cycle.
  always @(posedge clk) begin
    if (long_hold && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any transaction on either channel clears the quiet count.
  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (frame_valid && !frame_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("ascii_hex_can_frame_parser test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one character and returns at the edge where it is accepted. Idle cycles are
  // drawn before the character, so valid is only ever lowered on a step where the
  // previous transaction has just completed.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_byte  <= c;
    last_char  <= is_last;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) begin
      send_char(msg[i], i == msg.size() - 1);
    end
  endtask

  // The sender stops until every predicted frame has been delivered. The pending count
  // is registered in the checker, so it is trusted only after the task has waited for a clock edge.
  task automatic drain();
    char_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_text(input string s);
    msg.delete();
    for (int i = 0; i < s.len(); i++) begin
      msg.push_back(s[i]);
    end
  endtask

  // Hex digits above nine come out in upper or lower case at random.
  task automatic push_hex(input logic [3:0] v);
    if (v < 4'd10) begin
      msg.push_back(8'("0") + 8'(v));
    end else if ($urandom_range(1)) begin
      msg.push_back(8'("A") + 8'(v) - 8'd10);
    end else begin
      msg.push_back(8'("a") + 8'(v) - 8'd10);
    end
  endtask

  // A message in the well-formed syntax with random content: optional identifier of either size,
  // R or N, zero to eight payload bytes and any legal amount of the terminator, with trailing
  // characters after the LF now and then; the shortest can fall below the minimum length.
  task automatic build_good_message();
    int id_form;
    int n_bytes;
    int term;
    msg.delete();
    msg.push_back(CH_COLON);
    id_form = $urandom_range(2);
    if (id_form == 0) begin
      msg.push_back(CH_X);
      repeat (EXT_ID_DIGITS) push_hex(4'($urandom_range(15)));
    end else if (id_form == 1) begin
      msg.push_back(CH_S);
      repeat (STD_ID_DIGITS) push_hex(4'($urandom_range(15)));
    end
    msg.push_back($urandom_range(1) ? CH_R : CH_N);
    n_bytes = $urandom_range(MAX_DATA_BYTES);
    repeat (2 * n_bytes) push_hex(4'($urandom_range(15)));
    term = $urandom_range(4);
    if (term >= 1) msg.push_back(CH_SEMI);
    if (term >= 2) msg.push_back(CH_CR);
    if (term >= 3) msg.push_back(CH_LF);
    if (term == 4) begin
      repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom_range(255)));
    end
  endtask

  // Mostly well-formed messages; about a quarter are altered by an overwritten,
  // inserted or dropped character, and a tenth are plain noise.
  task automatic build_random_message();
    int kind;
    int pos;
    int keep;
    kind = $urandom_range(99);
    if (kind < 10) begin
      msg.delete();
      if ($urandom_range(1)) msg.push_back(CH_COLON);
      repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom_range(255)));
    end else begin
      build_good_message();
      if (kind < 35) begin
        pos = $urandom_range(msg.size() - 1);
        case ($urandom_range(2))
          0: msg[pos] = 8'($urandom_range(255));
          1: msg.insert(pos, 8'($urandom_range(255)));
          default: begin
            // Cutting the message short lands inside the identifier, before R or N,
            // or halfway through a payload byte as often as anywhere else.
            keep = $urandom_range(1, msg.size());
            while (msg.size() > keep) void'(msg.pop_back());
          end
        endcase
      end
    end
  endtask

  initial begin
    int phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed messages, all sent with no idling on either side.
    // Extended identifier, remote request, a full payload and the whole terminator.
    load_text(":X1fFfA0b9R0123456789aBcDeF;");
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    send_message();
    // All-ones identifier and payload, ending straight after the payload.
    load_text(":XFFFFFFFFNFFFFFFFFFFFFFFFF");
    send_message();
    // All-zeros identifier, ending after the CR.
    load_text(":X00000000N00;");
    msg.push_back(CH_CR);
    send_message();
    // Standard identifier, exactly the minimum length, ending after the semicolon.
    load_text(":S7a0N;");
    send_message();
    // No identifier; the characters after the LF make up the minimum length.
    load_text(":N;");
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    msg.push_back(8'hFF);
    msg.push_back(8'h80);
    send_message();
    // A message that is too short.
    load_text(":R00");
    send_message();
    // A bad first character.
    load_text("X:S1N;;;");
    send_message();
    // A bad hex digit in the identifier.
    load_text(":S12gN;");
    send_message();
    // Neither R nor N after the identifier.
    load_text(":S123Q00;");
    send_message();
    // A ninth payload byte.
    load_text(":N00112233445566778899");
    send_message();
    // LF where the CR belongs, then CR where the LF belongs.
    load_text(":S000N;");
    msg.push_back(CH_LF);
    send_message();
    load_text(":S000N;");
    msg.push_back(CH_CR);
    msg.push_back(CH_CR);
    send_message();
    // Ending inside the identifier, before R or N, and after half a payload byte.
    load_text(":X1234");
    send_message();
    load_text(":X12345678");
    send_message();
    load_text(":N12345");
    send_message();
    // A bad payload digit followed by characters that must all be ignored.
    load_text(":S1a2RG1;");
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    send_message();
    drain();

    // Random phases. The first one also holds the receiver off for a long stretch while
    // characters keep coming, so the result register fills and the input stalls.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          long_hold <= 1'b1;
        end
        1: begin
          send_idle_pct = 66;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 66;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct <= 25;
        end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < CHARS_PER_PHASE) begin
        build_random_message();
        send_message();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("ascii_hex_can_frame_parser test passed");
    end else begin
      $display("ascii_hex_can_frame_parser test failed");
    end
    $finish;
  end

endmodule
